// File: hw/rtl/tcw_pkg.sv
// tcw_pkg: shared types and codes for the text console writer
// no dependencies; used by the channel interfaces and the top level
package tcw_pkg;

    typedef logic [1:0]  t_action;
    typedef logic [7:0]  t_char;
    typedef logic [10:0] t_cell_index;
    typedef logic [15:0] t_cell;
    typedef logic [7:0]  t_attr;

    localparam int unsigned INDEX_W = 11;

    localparam t_action ACT_PUT   = 2'd0;
    localparam t_action ACT_CLEAR = 2'd1;
    localparam t_action ACT_READ  = 2'd2;

    localparam t_char CH_LF    = 8'd10;
    localparam t_char CH_CR    = 8'd13;
    localparam t_char CH_BS    = 8'd8;
    localparam t_char CH_TAB   = 8'd9;
    localparam t_char CH_SPACE = 8'h20;

    localparam t_attr RESET_ATTR = 8'h07;

endpackage

// File: hw/rtl/tcw_in_if.sv
// tcw_in_if: request channel of the text console writer
// depends on tcw_pkg for the payload types
interface tcw_in_if;
    logic                 valid;
    logic                 ready;
    tcw_pkg::t_action     action;
    tcw_pkg::t_char       char_code;
    tcw_pkg::t_cell_index read_index;

    modport source (output valid, output action, output char_code, output read_index,
                    input ready);
    modport sink   (input valid, input action, input char_code, input read_index,
                    output ready);
endinterface

// File: hw/rtl/tcw_out_if.sv
// tcw_out_if: result channel of the text console writer
// depends on tcw_pkg for the payload types
interface tcw_out_if;
    logic                 valid;
    logic                 ready;
    tcw_pkg::t_cell_index cursor_position;
    tcw_pkg::t_cell       cell_value;

    modport source (output valid, output cursor_position, output cell_value, input ready);
    modport sink   (input valid, input cursor_position, input cell_value, output ready);
endinterface

// File: hw/rtl/tcw_cfg_if.sv
// tcw_cfg_if: attribute register write channel of the text console writer
// depends on tcw_pkg for the payload type
interface tcw_cfg_if;
    logic           valid;
    logic           ready;
    tcw_pkg::t_attr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tcw_ram.sv
// tcw_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/text_console_writer.sv
// text_console_writer: text screen buffer with cursor, control bytes and scrolling
// an in-range read passes the registered RAM read port; a put that scrolls copies one
// cell per cycle through the RAM; one item at a time
// a new item is taken while the previous result waits to transfer
// reset: sync active low; a clearing pass fills the screen with space on attribute 0x07,
// input not ready meanwhile, attribute writes taken at any time
module text_console_writer #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_WIDTH      = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out,
    tcw_cfg_if.sink    i_cfg
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int XW  = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int CLW = $clog2(SCREEN_COLUMNS + 1);
    localparam int CSW = $clog2(SCREEN_COLUMNS + TAB_WIDTH);
    localparam int RW  = $clog2(SCREEN_ROWS);
    localparam int PW  = $clog2(TAB_WIDTH);
    localparam int DW  = $clog2(TAB_WIDTH + 1);

    localparam logic [AW-1:0]  LAST_CELL   = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]  LAST_COPY   = AW'(CELL_COUNT - SCREEN_COLUMNS - 1);
    localparam logic [AW-1:0]  BOTTOM_LIN  = AW'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [AW-1:0]  COLS_A      = AW'(SCREEN_COLUMNS);
    localparam logic [CLW-1:0] LAST_COL    = CLW'(SCREEN_COLUMNS - 1);
    localparam logic [CSW-1:0] COLS_S      = CSW'(SCREEN_COLUMNS);
    localparam logic [RW-1:0]  LAST_ROW    = RW'(SCREEN_ROWS - 1);
    localparam logic [PW-1:0]  LAST_PHASE  = PW'(TAB_WIDTH - 1);
    localparam logic [DW-1:0]  TAB_D       = DW'(TAB_WIDTH);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_RD        = 3'd1;
    localparam logic [2:0] S_SCR_PRIME = 3'd2;
    localparam logic [2:0] S_SCR_CP    = 3'd3;
    localparam logic [2:0] S_FILL      = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0]     r_state, n_state;
    logic           r_init, n_init;
    logic [AW-1:0]  r_addr, n_addr;
    logic [RW-1:0]  r_row, n_row;
    logic [CLW-1:0] r_col, n_col;
    logic [PW-1:0]  r_ph, n_ph;
    logic [AW-1:0]  r_lin, n_lin;
    t_attr          r_attr;
    t_cell          r_cell, n_cell;
    logic           r_out_valid, n_out_valid;
    t_cell_index    r_out_pos, n_out_pos;
    t_cell          r_out_cell, n_out_cell;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    t_cell          ram_wdata, ram_rdata;

    logic           in_xfer;
    logic           nl;
    logic [DW-1:0]  tab_delta;
    logic [CSW-1:0] tab_col;
    logic [XW-1:0]  idx_x, lin_x;
    t_cell          blank_cell;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_out_valid;
    assign o_out.cursor_position = r_out_pos;
    assign o_out.cell_value      = r_out_cell;

    assign tab_delta  = TAB_D - DW'(r_ph);
    assign tab_col    = CSW'(r_col) + CSW'(tab_delta);
    assign idx_x      = XW'(i_in.read_index);
    assign lin_x      = XW'(r_lin);
    // the power-on pass always blanks with the reset attribute
    assign blank_cell = {(r_init ? RESET_ATTR : r_attr), CH_SPACE};

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_addr      = r_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_ph        = r_ph;
        n_lin       = r_lin;
        n_cell      = r_cell;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_cell  = r_out_cell;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = blank_cell;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        nl          = 1'b0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cell  = '0;
                    n_state = S_DONE;
                    unique case (i_in.action)
                        ACT_PUT: begin
                            unique case (i_in.char_code)
                                CH_LF: begin
                                    nl = 1'b1;
                                end
                                CH_CR: begin
                                    n_col = '0;
                                    n_ph  = '0;
                                    n_lin = r_lin - AW'(r_col);
                                end
                                CH_BS: begin
                                    if (r_col != '0) begin
                                        n_col     = r_col - 1'b1;
                                        n_lin     = r_lin - 1'b1;
                                        n_ph      = (r_ph == '0) ? LAST_PHASE : r_ph - 1'b1;
                                        ram_we    = 1'b1;
                                        ram_waddr = r_lin - 1'b1;
                                    end
                                end
                                CH_TAB: begin
                                    if (tab_col >= COLS_S) begin
                                        nl = 1'b1;
                                    end else begin
                                        n_col = tab_col[CLW-1:0];
                                        n_lin = r_lin + AW'(tab_delta);
                                        n_ph  = '0;
                                    end
                                end
                                default: begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_lin;
                                    ram_wdata = {r_attr, i_in.char_code};
                                    if (r_col == LAST_COL) begin
                                        nl = 1'b1;
                                    end else begin
                                        n_col = r_col + 1'b1;
                                        n_lin = r_lin + 1'b1;
                                        n_ph  = (r_ph == LAST_PHASE) ? '0 : r_ph + 1'b1;
                                    end
                                end
                            endcase
                            if (nl) begin
                                n_col = '0;
                                n_ph  = '0;
                                if (r_row == LAST_ROW) begin
                                    n_lin   = BOTTOM_LIN;
                                    n_addr  = '0;
                                    n_state = S_SCR_PRIME;
                                end else begin
                                    n_row = r_row + 1'b1;
                                    n_lin = r_lin - AW'(r_col) + COLS_A;
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_ph    = '0;
                            n_lin   = '0;
                            n_addr  = '0;
                            n_state = S_FILL;
                        end
                        ACT_READ: begin
                            if (32'(i_in.read_index) < CELL_COUNT) begin
                                ram_re    = 1'b1;
                                ram_raddr = idx_x[AW-1:0];
                                n_state   = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_SCR_PRIME: begin
                ram_re    = 1'b1;
                ram_raddr = r_addr + COLS_A;
                n_state   = S_SCR_CP;
            end
            S_SCR_CP: begin
                // write the row below into this cell while fetching the next one
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = ram_rdata;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_COPY) begin
                    n_state = S_FILL;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + 1'b1 + COLS_A;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = lin_x[INDEX_W-1:0];
                    n_out_cell  = r_cell;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_ph        <= '0;
            r_lin       <= '0;
            r_attr      <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_ph        <= n_ph;
            r_lin       <= n_lin;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_attr <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell     <= n_cell;
        r_out_pos  <= n_out_pos;
        r_out_cell <= n_out_cell;
    end

    // no request taken before the power-on pass is over
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_init)
        else $error("input ready during power-on clear");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr <= LAST_CELL))
        else $error("screen write beyond last cell");

    // linear cursor is kept incrementally and must match row and column
    a_cursor_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (32'(r_lin) == 32'(r_row) * SCREEN_COLUMNS + 32'(r_col)))
        else $error("linear cursor out of step with row and column");

    a_tab_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_ph) == 32'(r_col) % TAB_WIDTH))
        else $error("tab phase out of step with column");

    a_done_follows_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.action == ACT_PUT && i_in.char_code == CH_CR) |=>
            (r_state == S_DONE))
        else $error("return did not complete in one step");

endmodule

// File: tb/text_console_writer_checker.sv
// text_console_writer_checker: watches the request, result and attribute channels of the
// console writer, keeps its own screen copy and compares every result field by field
// depends on tcw_pkg and the tcw_in_if, tcw_out_if and tcw_cfg_if interfaces
module text_console_writer_checker #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_WIDTH      = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tcw_in_if    i_req,
    tcw_out_if   i_rsp,
    tcw_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_failures,
    output int   o_checked
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;

    typedef struct packed {
        t_cell_index cursor_position;
        t_cell       cell_value;
    } t_console_result;

    t_cell           screen_copy [CELL_COUNT];
    int              cur_row;
    int              cur_col;
    t_attr           text_attr;
    t_console_result awaited_results [$];

    function automatic void start_next_line();
        cur_col = 0;
        if (cur_row == SCREEN_ROWS - 1) begin
            // bottom row: shift everything up one row, new bottom row blank
            for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
                screen_copy[i] = screen_copy[i + SCREEN_COLUMNS];
            for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
                screen_copy[i] = {text_attr, CH_SPACE};
        end else begin
            cur_row++;
        end
    endfunction

    function automatic t_console_result apply_request(t_action act, t_char ch,
                                                      t_cell_index idx);
        t_console_result res;
        res.cell_value = '0;
        case (act)
            ACT_PUT: begin
                case (ch)
                    CH_LF: start_next_line();
                    CH_CR: cur_col = 0;
                    CH_BS: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            screen_copy[cur_row * SCREEN_COLUMNS + cur_col] =
                                {text_attr, CH_SPACE};
                        end
                    end
                    CH_TAB: begin
                        cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
                        if (cur_col >= SCREEN_COLUMNS) start_next_line();
                    end
                    default: begin
                        screen_copy[cur_row * SCREEN_COLUMNS + cur_col] = {text_attr, ch};
                        cur_col++;
                        if (cur_col >= SCREEN_COLUMNS) start_next_line();
                    end
                endcase
            end
            ACT_CLEAR: begin
                foreach (screen_copy[i]) screen_copy[i] = {text_attr, CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ: begin
                // reads past the last cell give zero
                if (int'(idx) < CELL_COUNT) res.cell_value = screen_copy[idx];
            end
            default: ;
        endcase
        res.cursor_position = t_cell_index'(cur_row * SCREEN_COLUMNS + cur_col);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_console_result head;
        if (!i_rst_n) begin
            foreach (screen_copy[i]) screen_copy[i] = {RESET_ATTR, CH_SPACE};
            cur_row    = 0;
            cur_col    = 0;
            text_attr  = RESET_ATTR;
            awaited_results.delete();
            o_failures = 0;
            o_checked  = 0;
        end else begin
            // result first: it always belongs to an earlier request
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with none awaited: cursor %0d cell %h",
                             $time, i_rsp.cursor_position, i_rsp.cell_value);
                    o_failures++;
                end else begin
                    head = awaited_results.pop_front();
                    o_checked++;
                    if (i_rsp.cursor_position !== head.cursor_position) begin
                        $display("%0t: cursor_position expected %0d actual %0d",
                                 $time, head.cursor_position, i_rsp.cursor_position);
                        o_failures++;
                    end
                    if (i_rsp.cell_value !== head.cell_value) begin
                        $display("%0t: cell_value expected %h actual %h",
                                 $time, head.cell_value, i_rsp.cell_value);
                        o_failures++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) text_attr = i_cfg.data;
            if (i_req.valid && i_req.ready)
                awaited_results.push_back(apply_request(i_req.action, i_req.char_code,
                                                        i_req.read_index));
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: tb/text_console_writer_tb.sv
// text_console_writer_tb: clock, reset and stimulus for the console writer, directed
// items then random phases with sender gaps and receiver stalls
// depends on tcw_pkg, the three channel interfaces, the block and its checker
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int SCREEN_COLUMNS  = 80;
    localparam int SCREEN_ROWS     = 25;
    localparam int TAB_WIDTH       = 8;
    localparam int CELL_COUNT      = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int CYCLE_LIMIT     = 8_000_000;

    localparam t_action     ACT_UNUSED = 2'd3;
    localparam t_cell_index MAX_INDEX  = '1;

    logic  clk = 1'b0;
    logic  rst_n;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    int    cycle_count;
    int    pending;
    int    failures;
    int    checked;
    int    puts_sent;
    int    clears_sent;
    int    reads_sent;
    int    unused_sent;
    int    attr_writes;
    int    phase_idle [4]  = '{0, 72, 0, 37};
    int    phase_stall [4] = '{0, 0, 72, 37};
    t_attr phase_attr [4];

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();
    tcw_cfg_if cfg_ch ();

    text_console_writer #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TAB_WIDTH      (TAB_WIDTH)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    text_console_writer_checker #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TAB_WIDTH      (TAB_WIDTH)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (in_ch),
        .i_rsp      (out_ch),
        .i_cfg      (cfg_ch),
        .o_pending  (pending),
        .o_failures (failures),
        .o_checked  (checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("text_console_writer verification failed");
            $finish;
        end
    end

    // valid stays up across back-to-back transfers, one assignment per step
    task automatic send_item(t_action act, t_char ch, t_cell_index idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.char_code  <= ch;
        in_ch.read_index <= idx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        case (act)
            ACT_PUT:   puts_sent++;
            ACT_CLEAR: clears_sent++;
            ACT_READ:  reads_sent++;
            default:   unused_sent++;
        endcase
    endtask

    task automatic put_byte(t_char ch);
        send_item(ACT_PUT, ch, t_cell_index'($urandom_range(2047)));
    endtask

    task automatic read_cell(t_cell_index idx);
        send_item(ACT_READ, t_char'($urandom_range(255)), idx);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_attribute(t_attr value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        attr_writes++;
    endtask

    initial begin
        int pick;
        int burst;
        int sent;
        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'h00;
        phase_attr[2] = t_attr'($urandom_range(255));
        phase_attr[3] = 8'h1E;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_PUT;
        in_ch.char_code  <= '0;
        in_ch.read_index <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;
        rst_n            <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, last cell, just past the screen and the top index
        read_cell('0);
        read_cell(t_cell_index'(CELL_COUNT - 1));
        read_cell(t_cell_index'(CELL_COUNT));
        read_cell(MAX_INDEX);
        // backspace at column 0 is a no-op
        put_byte(CH_BS);
        put_byte(8'h48);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_BS);
        put_byte(CH_TAB);
        put_byte(CH_TAB);
        read_cell(t_cell_index'(0));
        read_cell(t_cell_index'(1));
        read_cell(t_cell_index'(2));
        put_byte(CH_CR);
        put_byte(CH_LF);
        send_item(ACT_UNUSED, 8'hFF, MAX_INDEX);
        put_byte(8'h78);
        read_cell(t_cell_index'(SCREEN_COLUMNS));
        send_item(ACT_CLEAR, 8'hFF, MAX_INDEX);
        read_cell(t_cell_index'(0));
        read_cell(t_cell_index'(SCREEN_COLUMNS));

        for (int phase = 0; phase < 4; phase++) begin
            write_attribute(phase_attr[phase]);
            sender_idle_pct    = phase_idle[phase];
            receiver_stall_pct = phase_stall[phase];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    // run of up to 30 newlines, which can reach the bottom row and scroll
                    burst = $urandom_range(30, 1);
                    repeat (burst) put_byte(CH_LF);
                    sent += burst;
                end else if (pick < 9) begin
                    // line of text of up to 90 bytes, which can be long enough to wrap
                    burst = $urandom_range(90, 1);
                    repeat (burst) put_byte(t_char'($urandom_range(255)));
                    sent += burst;
                end else if (pick < 11) begin
                    send_item(ACT_CLEAR, t_char'($urandom_range(255)),
                              t_cell_index'($urandom_range(2047)));
                    sent++;
                end else if (pick < 13) begin
                    send_item(ACT_UNUSED, t_char'($urandom_range(255)),
                              t_cell_index'($urandom_range(2047)));
                    sent++;
                end else if (pick < 30) begin
                    if ($urandom_range(9) == 0)
                        read_cell(t_cell_index'($urandom_range(2047, CELL_COUNT)));
                    else
                        read_cell(t_cell_index'($urandom_range(CELL_COUNT - 1)));
                    sent++;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 10)      put_byte(CH_LF);
                    else if (pick < 16) put_byte(CH_CR);
                    else if (pick < 28) put_byte(CH_BS);
                    else if (pick < 40) put_byte(CH_TAB);
                    else                put_byte(t_char'($urandom_range(255)));
                    sent++;
                end
                if ($urandom_range(99) < 2) wait_drained();
            end
        end

        wait_drained();
        repeat (CELL_COUNT + 10) @(posedge clk);
        $display("covered %0d puts, %0d clears, %0d reads, %0d unused actions",
                 puts_sent, clears_sent, reads_sent, unused_sent);
        $display("over %0d attribute settings; %0d results compared, %0d mismatches",
                 attr_writes + 1, checked, failures);
        if (failures == 0)
            $display("text_console_writer verification clean");
        else
            $display("text_console_writer verification failed");
        $finish;
    end

endmodule
